// File: hw/rtl/lfms_pkg.sv
// Shared types, sizes and codes for the leftmost-fill multi-stack block.
// No dependencies; the controller, datapath, top and bench files import this package.
package lfms_pkg;

   localparam int NUM_STACKS  = 16;
   localparam int STACK_DEPTH = 16;

   localparam int KIND_W   = 2;
   localparam int WORD_W   = 32;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int TOUCH_W  = 4;
   localparam int CAP_W    = 5;

   localparam int STORE_DEPTH = NUM_STACKS * STACK_DEPTH;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int STK_W       = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 2'd0,
      KIND_POP    = 2'd1,
      KIND_POP_AT = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SELECT,
      S_ACCESS,
      S_RESPOND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic select;
      logic access;
      logic respond;
   } cmd_type;

endpackage

// File: hw/rtl/lfms_ram.sv
// Generic single-port word store with registered read data.
// No dependencies.
module lfms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lfms_ctrl.sv
// Sequencer for the multi-stack: walks each beat through select, access
// and respond. Depends on lfms_pkg.
module lfms_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output lfms_pkg::cmd_type cmd
);
   import lfms_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (start) state_in = S_SELECT;
         S_SELECT:  state_in = S_ACCESS;
         S_ACCESS:  state_in = S_RESPOND;
         S_RESPOND: state_in = start ? S_SELECT : S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // A new beat may enter while the previous result is on the strobe.
   always_comb begin
      busy        = 1'b0;
      cmd.select  = 1'b0;
      cmd.access  = 1'b0;
      cmd.respond = 1'b0;
      case (state_ff)
         S_IDLE:    busy = 1'b0;
         S_SELECT:  begin busy = 1'b1; cmd.select = 1'b1; end
         S_ACCESS:  begin busy = 1'b1; cmd.access = 1'b1; end
         S_RESPOND: cmd.respond = 1'b1;
         default:   busy = 1'b0;
      endcase
      cmd.load = accept;
   end

   a_load_then_select: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.select)
      else $error("accepted beat did not enter select");

   a_select_then_access: assert property (@(posedge clock) disable iff (reset)
      cmd.select |=> cmd.access)
      else $error("select not followed by access");

   a_access_then_respond: assert property (@(posedge clock) disable iff (reset)
      cmd.access |=> cmd.respond)
      else $error("access not followed by respond");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.select, cmd.access, cmd.respond}))
      else $error("more than one step active");

endmodule

// File: hw/rtl/lfms_datapath.sv
// Datapath of the multi-stack: request registers, fill counts, priority
// encoders and the shared word store. Depends on lfms_pkg and lfms_ram.
module lfms_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  lfms_pkg::cmd_type              cmd,
   input  logic [lfms_pkg::KIND_W-1:0]    req_kind,
   input  logic [lfms_pkg::WORD_W-1:0]    req_value,
   input  logic [lfms_pkg::INDEX_W-1:0]   req_stack_index,
   input  logic                           csr_wr_en,
   input  logic [lfms_pkg::CAP_W-1:0]     csr_wr_data,
   output logic [lfms_pkg::WORD_W-1:0]    rsp_popped_value,
   output logic [lfms_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lfms_pkg::TOUCH_W-1:0]   rsp_stack_touched
);
   import lfms_pkg::*;

   localparam int SLOT_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [KIND_W-1:0]   kind_ff;
   logic [WORD_W-1:0]   value_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic [CAP_W-1:0]    capacity_ff;
   logic [CNT_W-1:0]    fill_ff [NUM_STACKS];

   logic [STK_W-1:0]    sel_ff,    sel_in;
   logic                ok_ff,     ok_in;
   logic                push_ff,   push_in;
   logic [SLOT_W-1:0]   slot_ff,   slot_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [TOUCH_W-1:0]  touched_ff;

   logic [CNT_W-1:0]    eff_cap;
   logic                push_found;
   logic [STK_W-1:0]    push_sel;
   logic                pop_found;
   logic [STK_W-1:0]    pop_sel;
   logic                named_ok;
   logic [STK_W-1:0]    named_sel;
   logic [CNT_W-1:0]    sel_fill;
   logic [ADDR_W-1:0]   addr;
   logic [WORD_W-1:0]   rd_data;
   logic                mem_wr;
   logic                mem_rd;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
         index_ff <= req_stack_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // Clamp capacity to 1..STACK_DEPTH.
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (int'(capacity_ff) > STACK_DEPTH) begin
         eff_cap = CNT_W'(STACK_DEPTH);
      end else begin
         eff_cap = CNT_W'(capacity_ff);
      end
   end

   // Lowest stack below capacity, highest non-empty stack.
   always_comb begin
      push_found = 1'b0;
      push_sel   = '0;
      pop_found  = 1'b0;
      pop_sel    = '0;
      for (int s = NUM_STACKS - 1; s >= 0; s--) begin
         if (fill_ff[s] < eff_cap) begin
            push_found = 1'b1;
            push_sel   = STK_W'(s);
         end
      end
      for (int s = 0; s < NUM_STACKS; s++) begin
         if (fill_ff[s] != '0) begin
            pop_found = 1'b1;
            pop_sel   = STK_W'(s);
         end
      end
   end

   always_comb begin
      named_sel = STK_W'(index_ff);
      named_ok  = (int'(index_ff) < NUM_STACKS) && (fill_ff[named_sel] != '0);
   end

   always_comb begin
      push_in = 1'b0;
      ok_in   = 1'b0;
      sel_in  = '0;
      case (kind_ff)
         KIND_PUSH: begin
            push_in = 1'b1;
            ok_in   = push_found;
            sel_in  = push_sel;
         end
         KIND_POP: begin
            ok_in  = pop_found;
            sel_in = pop_sel;
         end
         KIND_POP_AT: begin
            ok_in  = named_ok;
            sel_in = named_sel;
         end
         default: ok_in = 1'b0;
      endcase
      sel_fill = fill_ff[sel_in];
      slot_in  = push_in ? SLOT_W'(sel_fill) : SLOT_W'(sel_fill - CNT_W'(1));
      if (ok_in) begin
         status_in = STAT_DONE;
      end else if (push_in) begin
         status_in = STAT_FULL;
      end else begin
         status_in = STAT_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.select) begin
         sel_ff     <= sel_in;
         ok_ff      <= ok_in;
         push_ff    <= push_in;
         slot_ff    <= slot_in;
         status_ff  <= status_in;
         touched_ff <= ok_in ? TOUCH_W'(sel_in) : '0;
      end
   end

   // Commit the count change in the same cycle as the store access.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STACKS; s++) begin
            fill_ff[s] <= '0;
         end
      end else if (cmd.access && ok_ff) begin
         if (push_ff) begin
            fill_ff[sel_ff] <= fill_ff[sel_ff] + CNT_W'(1);
         end else begin
            fill_ff[sel_ff] <= fill_ff[sel_ff] - CNT_W'(1);
         end
      end
   end

   assign addr   = ADDR_W'(int'(sel_ff) * STACK_DEPTH + int'(slot_ff));
   assign mem_wr = cmd.access && ok_ff && push_ff;
   assign mem_rd = cmd.access && ok_ff && !push_ff;

   lfms_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .rd_en   (mem_rd),
      .addr    (addr),
      .wr_data (value_ff),
      .rd_data (rd_data)
   );

   assign rsp_popped_value  = (ok_ff && !push_ff) ? rd_data : '0;
   assign rsp_status        = status_ff;
   assign rsp_stack_touched = touched_ff;

   a_push_counts_up: assert property (@(posedge clock) disable iff (reset)
      (cmd.access && ok_ff && push_ff)
      |=> fill_ff[$past(sel_ff)] == $past(fill_ff[sel_ff]) + CNT_W'(1))
      else $error("push did not advance the fill count");

   a_fail_is_clean: assert property (@(posedge clock) disable iff (reset)
      (cmd.respond && status_ff != STAT_DONE)
      |-> (rsp_stack_touched == '0 && rsp_popped_value == '0))
      else $error("failed beat carries data");

endmodule

// File: hw/rtl/leftmost_fill_multi_stack.sv
// Leftmost-fill multi-stack: NUM_STACKS stacks sharing one word store.
// A beat accepted on start passes through select and store access before the
// result strobe rises; the result is taken at the edge that ends the strobe.
// busy covers select and store access, and a new start is taken during the
// cycle the previous result is strobed.
// Reset clears all fill counts and sets capacity to 16; the receiver cannot
// stall, each result is valid for exactly one cycle.
module leftmost_fill_multi_stack (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [lfms_pkg::KIND_W-1:0]    req_kind,
   input  logic [lfms_pkg::WORD_W-1:0]    req_value,
   input  logic [lfms_pkg::INDEX_W-1:0]   req_stack_index,
   output logic                           rsp_valid,
   output logic [lfms_pkg::WORD_W-1:0]    rsp_popped_value,
   output logic [lfms_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lfms_pkg::TOUCH_W-1:0]   rsp_stack_touched,
   input  logic                           csr_wr_en,
   input  logic [lfms_pkg::CAP_W-1:0]     csr_wr_data
);
   import lfms_pkg::*;

   cmd_type cmd;

   lfms_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   lfms_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_kind),
      .req_value         (req_value),
      .req_stack_index   (req_stack_index),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_status        (rsp_status),
      .rsp_stack_touched (rsp_stack_touched)
   );

   assign rsp_valid = cmd.respond;

endmodule

// File: bench/lfms_checker.sv
// Scoreboard for the leftmost-fill multi-stack: watches the request, result and
// capacity ports, keeps a shadow copy of the stacks and compares every result.
// Depends on lfms_pkg for sizes, kind codes and status codes.
module lfms_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [lfms_pkg::KIND_W-1:0]    req_kind,
   input  logic [lfms_pkg::WORD_W-1:0]    req_value,
   input  logic [lfms_pkg::INDEX_W-1:0]   req_stack_index,
   input  logic                           rsp_valid,
   input  logic [lfms_pkg::WORD_W-1:0]    rsp_popped_value,
   input  logic [lfms_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [lfms_pkg::TOUCH_W-1:0]   rsp_stack_touched,
   input  logic                           csr_wr_en,
   input  logic [lfms_pkg::CAP_W-1:0]     csr_wr_data,
   output int                             outstanding,
   output int                             mismatches
);
   import lfms_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0]  word;
      status_type         status;
      logic [TOUCH_W-1:0] touched;
   } plate_result_type;

   logic [WORD_W-1:0] shadow_store [STORE_DEPTH];
   logic [CNT_W-1:0]  shadow_fill [NUM_STACKS];
   logic [CAP_W-1:0]  shadow_cap;
   plate_result_type  pending_results [$];

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                  logic [WORD_W-1:0] want);
      $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Apply one command to the shadow stacks and return the result it should give.
   function automatic plate_result_type apply_plate_cmd(logic [KIND_W-1:0] kind,
                                                        logic [WORD_W-1:0] word,
                                                        logic [INDEX_W-1:0] idx);
      plate_result_type r;
      int limit;
      int target;
      r.word    = '0;
      r.status  = STAT_EMPTY;
      r.touched = '0;
      target    = -1;
      if (shadow_cap == 0)
         limit = 1;
      else if (int'(shadow_cap) > STACK_DEPTH)
         limit = STACK_DEPTH;
      else
         limit = int'(shadow_cap);
      case (kind)
         KIND_PUSH: begin
            r.status = STAT_FULL;
            for (int s = 0; s < NUM_STACKS; s++)
               if (target < 0 && int'(shadow_fill[s]) < limit) target = s;
            if (target >= 0) begin
               shadow_store[ADDR_W'(target * STACK_DEPTH
                                    + int'(shadow_fill[STK_W'(target)]))] = word;
               shadow_fill[STK_W'(target)] = shadow_fill[STK_W'(target)] + CNT_W'(1);
               r.status  = STAT_DONE;
               r.touched = TOUCH_W'(target);
            end
         end
         KIND_POP, KIND_POP_AT: begin
            if (kind == KIND_POP) begin
               // rightmost non-empty stack wins
               for (int s = NUM_STACKS - 1; s >= 0; s--)
                  if (target < 0 && shadow_fill[s] != 0) target = s;
            end else if (int'(idx) < NUM_STACKS && shadow_fill[idx] != 0) begin
               target = int'(idx);
            end
            if (target >= 0) begin
               shadow_fill[STK_W'(target)] = shadow_fill[STK_W'(target)] - CNT_W'(1);
               r.word    = shadow_store[ADDR_W'(target * STACK_DEPTH
                                               + int'(shadow_fill[STK_W'(target)]))];
               r.status  = STAT_DONE;
               r.touched = TOUCH_W'(target);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      plate_result_type want;
      if (reset) begin
         foreach (shadow_fill[i]) shadow_fill[i] = '0;
         shadow_cap = CAP_RESET;
         pending_results.delete();
      end else begin
         if (csr_wr_en) shadow_cap = csr_wr_data;
         // retire the result beat before taking a new command beat on the same edge
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result beat with nothing pending", rsp_popped_value, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_popped_value !== want.word)
                  report_mismatch("popped_value", rsp_popped_value, want.word);
               if (rsp_status !== want.status)
                  report_mismatch("status", WORD_W'(rsp_status), WORD_W'(want.status));
               if (rsp_stack_touched !== want.touched)
                  report_mismatch("stack_touched", WORD_W'(rsp_stack_touched),
                                  WORD_W'(want.touched));
            end
         end
         if (start && !busy)
            pending_results.push_back(apply_plate_cmd(req_kind, req_value,
                                                      req_stack_index));
      end
      outstanding <= pending_results.size();
   end

endmodule

// File: bench/leftmost_fill_multi_stack_test.sv
// Top of the leftmost-fill multi-stack bench: clock, reset, command and capacity
// stimulus, and the verdict. Depends on lfms_pkg, the block and lfms_checker.
module leftmost_fill_multi_stack_test;
   import lfms_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                start           = 1'b0;
   logic [KIND_W-1:0]   req_kind        = '0;
   logic [WORD_W-1:0]   req_value       = '0;
   logic [INDEX_W-1:0]  req_stack_index = '0;
   logic                csr_wr_en       = 1'b0;
   logic [CAP_W-1:0]    csr_wr_data     = '0;
   logic                busy;
   logic                rsp_valid;
   logic [WORD_W-1:0]   rsp_popped_value;
   logic [STATUS_W-1:0] rsp_status;
   logic [TOUCH_W-1:0]  rsp_stack_touched;
   int                  outstanding;
   int                  mismatches;
   int                  cycle_count = 0;

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   leftmost_fill_multi_stack uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_value         (req_value),
      .req_stack_index   (req_stack_index),
      .rsp_valid         (rsp_valid),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_status        (rsp_status),
      .rsp_stack_touched (rsp_stack_touched),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   lfms_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_value         (req_value),
      .req_stack_index   (req_stack_index),
      .rsp_valid         (rsp_valid),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_status        (rsp_status),
      .rsp_stack_touched (rsp_stack_touched),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .outstanding       (outstanding),
      .mismatches        (mismatches)
   );

   // Hold start high until the block takes the beat.
   task automatic send_beat(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] word,
                            logic [INDEX_W-1:0] idx);
      start           <= 1'b1;
      req_kind        <= kind;
      req_value       <= word;
      req_stack_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_sender(int pct);
      int n;
      n = 0;
      while (n < 8 && $urandom_range(99) < pct) n++;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drop start and wait until every pending result beat has come back.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_beat(int push_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < push_pct) begin
         send_beat(KIND_PUSH, $urandom, INDEX_W'($urandom));
      end else begin
         roll = $urandom_range(19);
         if (roll < 9)
            send_beat(KIND_POP, $urandom, INDEX_W'($urandom));
         else if (roll < 18)
            send_beat(KIND_POP_AT, $urandom, INDEX_W'($urandom));
         else
            send_beat(KIND_UNUSED, $urandom, INDEX_W'($urandom));
      end
   endtask

   task automatic run_phase(logic [CAP_W-1:0] cap, int beats, int push_pct,
                            int idle_pct);
      write_capacity(cap);
      for (int i = 0; i < beats; i++) begin
         idle_sender(idle_pct);
         random_beat(push_pct);
         if ($urandom_range(199) == 0) drain_results();
      end
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: empty pops, unused kind, two pushes landing on stack 0
      send_beat(KIND_POP, $urandom, '0);
      send_beat(KIND_POP_AT, '1, 4'd15);
      send_beat(KIND_UNUSED, '1, 4'd15);
      send_beat(KIND_PUSH, '1, '0);
      send_beat(KIND_PUSH, '0, 4'd15);
      send_beat(KIND_POP_AT, $urandom, '0);
      send_beat(KIND_POP, '0, '0);

      // capacity of one: one plate per stack, then all full
      write_capacity(5'd1);
      for (int i = 0; i < NUM_STACKS; i++)
         send_beat(KIND_PUSH, $urandom, INDEX_W'(i));
      send_beat(KIND_PUSH, '1, '0);
      send_beat(KIND_POP, $urandom, '0);
      send_beat(KIND_POP_AT, $urandom, 4'd15);
      send_beat(KIND_PUSH, $urandom, '0);
      send_beat(KIND_POP_AT, '1, '0);

      // capacity changes while stacks still hold plates, zero and the top codes
      run_phase(5'd16, 350, 90, 0);
      run_phase(5'd3,  250, 25, 73);
      run_phase(5'd0,  200, 30, 6);
      run_phase(5'd31, 200, 60, 73);
      run_phase(5'd17, 150, 35, 0);
      run_phase(5'd2,  150, 55, 6);

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/lfms_pkg.sv
hw/rtl/lfms_ram.sv
hw/rtl/lfms_ctrl.sv
hw/rtl/lfms_datapath.sv
hw/rtl/leftmost_fill_multi_stack.sv
bench/lfms_checker.sv
bench/leftmost_fill_multi_stack_test.sv
